// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bitmap fill engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/brrf_pkg.sv
// ----------------------------------------------------------------------------
// brrf_pkg
// Widths, defaults and command codes of the bitmap range and rectangle fill.
// ----------------------------------------------------------------------------
package brrf_pkg;

	localparam int unsigned DEF_NUM_WORDS   = 128;
	localparam int unsigned WORD_W          = 32;
	localparam int unsigned POS_W           = 13;
	localparam int unsigned IDX_W           = 7;
	localparam int unsigned NW_W            = 9;
	localparam int unsigned CFG_IDX_W       = 1;
	localparam int unsigned DEF_IMAGE_WIDTH = 64;
	localparam int unsigned DEF_ACTIVE_BITS = 4096;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	typedef enum logic [3:0] {
		REQ_CLEAR   = 4'd0,
		REQ_SET_ALL = 4'd1,
		REQ_RANGE   = 4'd2,
		REQ_RECT    = 4'd3,
		REQ_AND     = 4'd4,
		REQ_OR      = 4'd5,
		REQ_XOR     = 4'd6,
		REQ_WRITE   = 4'd7,
		REQ_READ    = 4'd8
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 1'b0,
		CFG_ACTIVE_BITS = 1'b1
	} cfg_reg_t;

	// bits of the word holding cur that fall inside [cur, stop)
	function automatic logic [WORD_W-1:0] fill_mask(logic [POS_W-1:0] cur,
			logic [POS_W-1:0] stop);
		logic [WORD_W-1:0] m;
		m = ALL_ONES << cur[4:0];
		if (stop[POS_W-1:5] == cur[POS_W-1:5]) begin
			m = m & ~(ALL_ONES << stop[4:0]);
		end
		return m;
	endfunction

endpackage

// File: sv/brrf_mem.sv
// ----------------------------------------------------------------------------
// brrf_mem
// Bitmap word store: one write and one registered read port, per-word valid
// bits so that unwritten or cleared words read as zero.
// ----------------------------------------------------------------------------
module brrf_mem import brrf_pkg::*; #(
	parameter int NUM_WORDS = DEF_NUM_WORDS,
	parameter int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata,
	input  logic              clr,
	input  logic [NW_W-1:0]   clr_words
);

	logic [WORD_W-1:0]    mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] valid_q;
	logic [WORD_W-1:0]    rdata_q;
	logic                 rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[raddr];
			for (int i = 0; i < NUM_WORDS; i++) begin
				if (clr && (i < int'(clr_words))) begin
					valid_q[i] <= 1'b0;
				end
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// File: sv/bitmap_range_rect_fill.sv
// ----------------------------------------------------------------------------
// bitmap_range_rect_fill
// Bitmap of 32-bit words with clear, set, range fill, rectangle fill and
// single-word commands, run one at a time by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start && !busy            req_type pos_a pos_b rect_width
//                                      rect_height word_index word_value
//  result    done (one cycle)          read_data error
//  config    cfg_valid && cfg_ready    cfg_index cfg_data
//
//  Clear, zero-height rectangle and rejected commands end after decode; a
//  rectangle out of bounds ends after the multiply and the bound check.
//  Set all writes one active word per sweep step. Word commands read, then
//  modify. Fills do one read-modify-write of the word store per word touched,
//  row by row, after a rectangle's multiply, check and offset. busy drops with
//  the result beat. Per-word valid bits clear at reset; results cannot stall.
// ----------------------------------------------------------------------------
module bitmap_range_rect_fill import brrf_pkg::*; #(
	parameter int NUM_WORDS = DEF_NUM_WORDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [3:0]           req_type,
	input  logic [POS_W-1:0]     pos_a,
	input  logic [POS_W-1:0]     pos_b,
	input  logic [POS_W-1:0]     rect_width,
	input  logic [POS_W-1:0]     rect_height,
	input  logic [IDX_W-1:0]     word_index,
	input  logic [WORD_W-1:0]    word_value,
	output logic                 done,
	output logic [WORD_W-1:0]    read_data,
	output logic                 error,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POS_W-1:0]     cfg_data
);

	localparam int AW  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CAP = NUM_WORDS * 32;
	localparam int LIM = (CAP > 8191) ? 8191 : CAP;
	localparam logic [POS_W-1:0] LIM_BITS = POS_W'(LIM);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SWEEP,
		ST_RECT_MUL,
		ST_RECT_CHK,
		ST_RECT_OFF,
		ST_ROW,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_WORD_RD,
		ST_WORD_OP
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [POS_W-1:0]    pa_q, pb_q, rw_q, rh_q;
	logic [IDX_W-1:0]    wi_q;
	logic [WORD_W-1:0]   wv_q;
	logic [POS_W-1:0]    iw_q, act_q;
	logic [26:0]         prod_q;
	logic [POS_W-1:0]    off_q, len_q, end_q, rows_q;
	logic [POS_W:0]      cur_q;
	logic [NW_W-1:0]     cnt_q;
	logic                done_q, err_q;
	logic [WORD_W-1:0]   rd_q;

	logic [POS_W-1:0]    live;
	logic [POS_W:0]      nw_sum;
	logic [NW_W-1:0]     nw;
	logic [POS_W:0]      mul_b;
	logic [26:0]         mul_p;
	logic [27:0]         last_end;
	logic [27:0]         rect_off;
	logic                mem_we, mem_clr;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [WORD_W-1:0]   mem_wdata, mem_rdata;

	assign live   = (act_q > LIM_BITS) ? LIM_BITS : act_q;
	assign nw_sum = {1'b0, live} + (POS_W+1)'(31);
	assign nw     = nw_sum[POS_W:5];

	// shared multiplier: last row index for the bound check, then first row
	assign mul_b    = (state_q == ST_RECT_MUL) ?
		({1'b0, pb_q} + {1'b0, rh_q} - (POS_W+1)'(1)) : {1'b0, pb_q};
	assign mul_p    = iw_q * mul_b;
	assign last_end = {1'b0, prod_q} + 28'(pa_q) + 28'(rw_q);
	assign rect_off = {1'b0, mul_p} + 28'(pa_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_clr   = 1'b0;
		mem_waddr = AW'(cur_q[POS_W-1:5]);
		mem_raddr = AW'(cur_q[POS_W-1:5]);
		mem_wdata = mem_rdata | fill_mask(cur_q[POS_W-1:0], end_q);
		case (state_q)
			ST_DECODE: begin
				mem_clr = (req_q == REQ_CLEAR);
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(cnt_q);
				mem_wdata = ALL_ONES;
			end
			ST_FILL_WR: begin
				mem_we = 1'b1;
			end
			ST_WORD_RD: begin
				mem_raddr = AW'(wi_q);
			end
			ST_WORD_OP: begin
				mem_waddr = AW'(wi_q);
				mem_raddr = AW'(wi_q);
				case (req_q)
					REQ_AND: begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata & wv_q;
					end
					REQ_OR: begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata | wv_q;
					end
					REQ_XOR: begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata ^ wv_q;
					end
					REQ_WRITE: begin
						mem_we    = 1'b1;
						mem_wdata = wv_q;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	brrf_mem #(
		.NUM_WORDS (NUM_WORDS),
		.AW        (AW)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata),
		.raddr     (mem_raddr),
		.rdata     (mem_rdata),
		.clr       (mem_clr),
		.clr_words (nw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q  <= POS_W'(DEF_IMAGE_WIDTH);
			act_q <= POS_W'(DEF_ACTIVE_BITS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: iw_q  <= cfg_data;
				CFG_ACTIVE_BITS: act_q <= cfg_data;
				default: begin
					iw_q <= iw_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
			rd_q    <= '0;
			cnt_q   <= '0;
			rows_q  <= '0;
			cur_q   <= '0;
			end_q   <= '0;
			off_q   <= '0;
			len_q   <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					err_q <= 1'b0;
					rd_q  <= '0;
					case (req_q)
						REQ_CLEAR: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						REQ_SET_ALL: begin
							cnt_q <= '0;
							if (nw == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_SWEEP;
							end
						end
						REQ_RANGE: begin
							if ((pa_q > pb_q) || (pb_q > live)) begin
								err_q   <= 1'b1;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								off_q   <= pa_q;
								len_q   <= pb_q - pa_q;
								rows_q  <= POS_W'(1);
								state_q <= ST_ROW;
							end
						end
						REQ_RECT: begin
							if (rh_q == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_RECT_MUL;
							end
						end
						REQ_AND, REQ_OR, REQ_XOR, REQ_WRITE, REQ_READ: begin
							if ({2'b00, wi_q} >= nw) begin
								err_q   <= 1'b1;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_WORD_RD;
							end
						end
						default: begin
							err_q   <= 1'b1;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + NW_W'(1);
					if ((cnt_q + NW_W'(1)) == nw) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RECT_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_RECT_CHK;
				end
				ST_RECT_CHK: begin
					if (last_end > 28'(live)) begin
						err_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RECT_OFF;
					end
				end
				ST_RECT_OFF: begin
					off_q   <= rect_off[POS_W-1:0];
					len_q   <= rw_q;
					// zero pitch puts every row on the same bits
					rows_q  <= (iw_q == '0) ? POS_W'(1) : rh_q;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (rows_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= {1'b0, off_q};
						end_q   <= off_q + len_q;
						off_q   <= off_q + iw_q;
						rows_q  <= rows_q - POS_W'(1);
						state_q <= ST_FILL_RD;
					end
				end
				ST_FILL_RD: begin
					if (cur_q >= {1'b0, end_q}) begin
						state_q <= ST_ROW;
					end else begin
						state_q <= ST_FILL_WR;
					end
				end
				ST_FILL_WR: begin
					cur_q   <= {cur_q[POS_W:5] + (POS_W-4)'(1), 5'b00000};
					state_q <= ST_FILL_RD;
				end
				ST_WORD_RD: begin
					state_q <= ST_WORD_OP;
				end
				ST_WORD_OP: begin
					if (req_q == REQ_READ) begin
						rd_q <= mem_rdata;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command payload: hold from the accepted beat
	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			req_q <= req_t'(req_type);
			pa_q  <= pos_a;
			pb_q  <= pos_b;
			rw_q  <= rect_width;
			rh_q  <= rect_height;
			wi_q  <= word_index;
			wv_q  <= word_value;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign read_data = rd_q;
	assign error     = err_q;
	assign cfg_ready = 1'b1;

endmodule

// File: sv/brrf_chk.sv
// ----------------------------------------------------------------------------
// brrf_chk
// Port-level checks of command and result sequencing of the fill engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brrf_chk import brrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 done,
	input  logic [WORD_W-1:0]    read_data,
	input  logic                 error
);

	`CHK_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accepted beat without busy")
	`CHK_ASSERT(a_done_after_busy, clk, arst_n, done |-> (!busy && $past(busy)), "result without work")
	`CHK_ASSERT(a_done_single, clk, arst_n, done |=> !done, "result beat repeated")
	`CHK_NEVER(a_err_no_data, clk, arst_n, done && error && (read_data != '0), "data on rejected beat")

endmodule

bind bitmap_range_rect_fill brrf_chk u_brrf_chk (.*);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap range and rectangle fill engine. A
// scoreboard class mirrors the word store and the two geometry registers,
// predicts the read data and error flag of each accepted command and checks
// every done beat against the oldest prediction. Stimulus runs a directed
// opening, then random commands over several geometry settings, with random
// sender gaps and idle pauses between settings.
// ----------------------------------------------------------------------------
module tb;
	import brrf_pkg::*;

	localparam int          STALL_LIMIT = 50000;
	localparam int          RECT_BUDGET = 3000;
	localparam int unsigned POS_MAX     = (1 << POS_W) - 1;
	localparam logic [3:0]  REQ_FIRST_UNDEF = 4'(REQ_READ) + 4'd1;
	localparam logic [3:0]  REQ_LAST_UNDEF  = '1;

	localparam int unsigned PITCH_SET [8] = '{1, 0, 4096, 37, 100, 13, 8191, 64};
	localparam int unsigned ACTIVE_SET [8] = '{4096, 1000, 4096, 0, 8191, 33, 4096, 4096};

	typedef struct {
		logic [3:0]        req;
		logic [POS_W-1:0]  pa;
		logic [POS_W-1:0]  pb;
		logic [POS_W-1:0]  rw;
		logic [POS_W-1:0]  rh;
		logic [IDX_W-1:0]  wi;
		logic [WORD_W-1:0] wv;
	} bitmap_cmd_t;

	typedef struct {
		logic [WORD_W-1:0] rd;
		logic              err;
	} bitmap_resp_t;

	class bitmap_scoreboard;
		logic [WORD_W-1:0] bitmap [DEF_NUM_WORDS];
		int unsigned       pitch;
		int unsigned       active_bits;
		bitmap_resp_t      expected_resp [$];
		int                mismatches;

		function new();
			foreach (bitmap[i]) bitmap[i] = '0;
			pitch       = DEF_IMAGE_WIDTH;
			active_bits = DEF_ACTIVE_BITS;
			mismatches  = 0;
		endfunction

		function int unsigned live_bits();
			int unsigned cap;
			cap = DEF_NUM_WORDS * WORD_W;
			return (active_bits < cap) ? active_bits : cap;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [POS_W-1:0] v);
			case (idx)
				CFG_IMAGE_WIDTH: pitch = v;
				CFG_ACTIVE_BITS: active_bits = v;
				default: ;
			endcase
		endfunction

		function void set_span(int unsigned lo, int unsigned hi);
			int unsigned       bo;
			int unsigned       n;
			logic [WORD_W-1:0] mask;
			while (lo < hi) begin
				bo = lo % WORD_W;
				n  = WORD_W - bo;
				if (hi - lo < n) n = hi - lo;
				mask = (n == WORD_W) ? ALL_ONES :
					((WORD_W'(1) << n) - WORD_W'(1)) << bo;
				bitmap[lo / WORD_W] |= mask;
				lo += n;
			end
		endfunction

		function void note_command(bitmap_cmd_t c);
			bitmap_resp_t r;
			int unsigned  len;
			int unsigned  nw;
			int unsigned  off;
			longint       row_end;
			len   = live_bits();
			nw    = (len + WORD_W - 1) / WORD_W;
			r.rd  = '0;
			r.err = 1'b0;
			case (c.req)
				REQ_CLEAR: for (int i = 0; i < nw; i++) bitmap[i] = '0;
				REQ_SET_ALL: for (int i = 0; i < nw; i++) bitmap[i] = ALL_ONES;
				REQ_RANGE: begin
					if (c.pa > c.pb || int'(c.pb) > len) r.err = 1'b1;
					else set_span(c.pa, c.pb);
				end
				REQ_RECT: begin
					if (c.rh != 0) begin
						row_end = longint'(pitch) * (longint'(c.pb) + longint'(c.rh) - 1)
							+ longint'(c.pa) + longint'(c.rw);
						if (row_end > longint'(len)) begin
							r.err = 1'b1;
						end else begin
							off = pitch * c.pb + c.pa;
							for (int i = 0; i < int'(c.rh); i++) begin
								set_span(off, off + c.rw);
								off += pitch;
							end
						end
					end
				end
				REQ_AND, REQ_OR, REQ_XOR, REQ_WRITE, REQ_READ: begin
					if (int'(c.wi) >= nw) begin
						r.err = 1'b1;
					end else begin
						case (c.req)
							REQ_AND:   bitmap[c.wi] &= c.wv;
							REQ_OR:    bitmap[c.wi] |= c.wv;
							REQ_XOR:   bitmap[c.wi] ^= c.wv;
							REQ_WRITE: bitmap[c.wi] = c.wv;
							default:   r.rd = bitmap[c.wi];
						endcase
					end
				end
				default: r.err = 1'b1;
			endcase
			expected_resp.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [WORD_W-1:0] rd, logic e);
			bitmap_resp_t want;
			if (expected_resp.size() == 0) begin
				report($sformatf("unexpected beat: read_data %h error %b", rd, e));
				return;
			end
			want = expected_resp.pop_front();
			if (rd !== want.rd)
				report($sformatf("read_data %h, want %h", rd, want.rd));
			if (e !== want.err)
				report($sformatf("error %b, want %b", e, want.err));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 busy;
	logic [3:0]           req_type    = '0;
	logic [POS_W-1:0]     pos_a       = '0;
	logic [POS_W-1:0]     pos_b       = '0;
	logic [POS_W-1:0]     rect_width  = '0;
	logic [POS_W-1:0]     rect_height = '0;
	logic [IDX_W-1:0]     word_index  = '0;
	logic [WORD_W-1:0]    word_value  = '0;
	logic                 done;
	logic [WORD_W-1:0]    read_data;
	logic                 error;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [POS_W-1:0]     cfg_data    = '0;

	bitmap_scoreboard sb;
	bit               burst        = 1'b0;
	int               stall_cycles = 0;

	bitmap_range_rect_fill u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.pos_a       (pos_a),
		.pos_b       (pos_b),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.word_index  (word_index),
		.word_value  (word_value),
		.done        (done),
		.read_data   (read_data),
		.error       (error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(read_data, error);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic bitmap_cmd_t pack_cmd(logic [3:0] req, int unsigned pa,
			int unsigned pb, int unsigned rw, int unsigned rh, int unsigned wi,
			logic [WORD_W-1:0] wv);
		bitmap_cmd_t c;
		c.req = req;
		c.pa  = POS_W'(pa);
		c.pb  = POS_W'(pb);
		c.rw  = POS_W'(rw);
		c.rh  = POS_W'(rh);
		c.wi  = IDX_W'(wi);
		c.wv  = wv;
		return c;
	endfunction

	function automatic bitmap_cmd_t make_cmd();
		bitmap_cmd_t c;
		int unsigned len;
		int unsigned nw;
		int unsigned rows;
		int unsigned pick;
		int          per_row;
		longint      row_end;
		len  = sb.live_bits();
		nw   = (len + WORD_W - 1) / WORD_W;
		c.pa = POS_W'($urandom);
		c.pb = POS_W'($urandom);
		c.rw = POS_W'($urandom);
		c.rh = POS_W'($urandom);
		c.wi = IDX_W'($urandom);
		c.wv = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			c.req = REQ_CLEAR;
		end else if (pick < 6) begin
			c.req = REQ_SET_ALL;
		end else if (pick < 28) begin
			c.req = REQ_RANGE;
			case ($urandom_range(0, 9))
				0: ;
				1: begin
					c.pa = POS_W'($urandom_range(0, len));
					c.pb = POS_W'(len + $urandom_range(0, 1));
				end
				2: begin
					c.pa = POS_W'($urandom_range(1, len + 1));
					c.pb = c.pa - POS_W'(1);
				end
				default: begin
					c.pa = POS_W'($urandom_range(0, len));
					c.pb = POS_W'($urandom_range(c.pa, len));
				end
			endcase
		end else if (pick < 50) begin
			c.req = REQ_RECT;
			if ($urandom_range(0, 4) != 0) begin
				rows = (sb.pitch != 0) ? len / sb.pitch : 8;
				c.rh = POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, rows + 1)
					: $urandom_range(0, 6));
				c.rw = POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, len)
					: $urandom_range(0, 100));
				c.pa = POS_W'($urandom_range(0, (sb.pitch != 0) ? sb.pitch : 64));
				c.pb = POS_W'($urandom_range(0, rows));
			end
			// cap the work of accepted fills
			if (c.rh != 0) begin
				row_end = longint'(sb.pitch) * (longint'(c.pb) + longint'(c.rh) - 1)
					+ longint'(c.pa) + longint'(c.rw);
				per_row = int'(c.rw) / WORD_W + 3;
				if (row_end <= longint'(len) && int'(c.rh) * per_row > RECT_BUDGET)
					c.rh = POS_W'(RECT_BUDGET / per_row);
			end
		end else if (pick < 97) begin
			if (pick < 58) c.req = REQ_AND;
			else if (pick < 66) c.req = REQ_OR;
			else if (pick < 74) c.req = REQ_XOR;
			else if (pick < 82) c.req = REQ_WRITE;
			else c.req = REQ_READ;
			if (nw != 0 && $urandom_range(0, 4) != 0)
				c.wi = IDX_W'($urandom_range(0, nw - 1));
			case ($urandom_range(0, 7))
				0: c.wv = '0;
				1: c.wv = ALL_ONES;
				default: ;
			endcase
		end else begin
			c.req = 4'($urandom_range(int'(REQ_FIRST_UNDEF), int'(REQ_LAST_UNDEF)));
		end
		return c;
	endfunction

	task automatic issue(bitmap_cmd_t c);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= c.req;
		pos_a       <= c.pa;
		pos_b       <= c.pb;
		rect_width  <= c.rw;
		rect_height <= c.rh;
		word_index  <= c.wi;
		word_value  <= c.wv;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	// hold off until every outstanding beat has come back
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (sb.expected_resp.size() != 0);
		@(posedge clk);
	endtask

	task automatic set_geometry(int unsigned pitch, int unsigned active);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= POS_W'(pitch);
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_IMAGE_WIDTH, POS_W'(pitch));
		cfg_index <= CFG_ACTIVE_BITS;
		cfg_data  <= POS_W'(active);
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_ACTIVE_BITS, POS_W'(active));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 0, '0));
		issue(pack_cmd(REQ_SET_ALL, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 127, ALL_ONES));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 127, '0));
		issue(pack_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, 0, DEF_ACTIVE_BITS, 0, 0, 0, '0));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 64, '0));
		issue(pack_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, 5, 5, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, 10, 9, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, 0, DEF_ACTIVE_BITS + 1, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, POS_MAX, POS_MAX, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, 3, 40, 0, 0, 0, '0));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 1, '0));
		issue(pack_cmd(REQ_RECT, 60, 1, 10, 3, 0, '0));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 3, '0));
		issue(pack_cmd(REQ_RECT, 0, 63, 65, 1, 0, '0));
		issue(pack_cmd(REQ_RECT, POS_MAX, POS_MAX, POS_MAX, 0, 0, '0));
		issue(pack_cmd(REQ_AND, 0, 0, 0, 0, 1, 32'hFFFF_0000));
		issue(pack_cmd(REQ_OR, 0, 0, 0, 0, 2, 32'h0000_00FF));
		issue(pack_cmd(REQ_XOR, 0, 0, 0, 0, 1, ALL_ONES));
		issue(pack_cmd(REQ_WRITE, 0, 0, 0, 0, 127, 32'hA5A5_5A5A));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 127, '0));
		issue(pack_cmd(REQ_FIRST_UNDEF, 0, 0, 0, 0, 0, '0));
		issue(pack_cmd(REQ_LAST_UNDEF, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 127, ALL_ONES));

		drain();
		set_geometry(0, 40);
		issue(pack_cmd(REQ_RECT, 2, 7, 10, 5, 0, '0));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 0, '0));
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 2, '0));
		issue(pack_cmd(REQ_SET_ALL, 0, 0, 0, 0, 0, '0));

		drain();
		set_geometry(DEF_IMAGE_WIDTH, 0);
		issue(pack_cmd(REQ_READ, 0, 0, 0, 0, 0, '0));
		issue(pack_cmd(REQ_RANGE, 0, 0, 0, 0, 0, '0));

		for (int p = 0; p < 10; p++) begin
			drain();
			if (p < 8) set_geometry(PITCH_SET[p], ACTIVE_SET[p]);
			else set_geometry($urandom_range(1, 300), $urandom_range(0, DEF_ACTIVE_BITS));
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(0, 15) == 0) burst = !burst;
				issue(make_cmd());
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: bitmap_range_rect_fill.f
+incdir+sv
sv/brrf_pkg.sv
sv/brrf_mem.sv
sv/bitmap_range_rect_fill.sv
sv/brrf_chk.sv
test/tb.sv
